// File: rtl/sit_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// String intern table package
// Shared types, hash constants and status codes.
// ----------------------------------------------------------------------------
package sit_pkg;

   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_HALF_LOAD = 2'd1,
      ST_STORE_FULL = 2'd2,
      ST_KEY_LONG  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_COLLECT,
      S_HASH,
      S_PROBE_RD,
      S_PROBE_CHK,
      S_CMP_RD,
      S_CMP_CHK,
      S_INS_CHK,
      S_INS_WR,
      S_SLOT_WR,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [7:0]  slot_index;
      logic [13:0] string_offset;
      logic        newly_added;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic [7:0] key_byte;
      logic       byte_present;
      logic       end_of_key;
   } req_type;

endpackage

// File: rtl/sit_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries one payload of parameterized type between source and sink.
// ----------------------------------------------------------------------------
interface sit_if #(parameter type T = logic);
   logic valid;
   logic ready;
   T     data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/string_intern_table_core.sv
`timescale 1ns / 1ps
// Sequencing: a request without end of key passes the hash state and returns to
// collect. A final request then probes slots, compares stored bytes and, on insert,
// writes the stored bytes ((length+1) rounded up to 8) and the slot; the response
// register follows. A new request is taken only in the collect state, and a final
// request holds off the next until its response is handed to the output register.
// Reset clears the slot valid bits, fill, entry count and the running hash.
// ----------------------------------------------------------------------------
// String intern table core
// FNV-1a hashed intern table with linear probing and a bump string store.
// ----------------------------------------------------------------------------
module string_intern_table_core
   import sit_pkg::*;
#(
   parameter int SLOTS       = 256,
   parameter int MAX_KEY     = 64,
   parameter int STORE_BYTES = 16384
) (
   input logic clock,
   input logic reset,
   sit_if.sink   req_if,
   sit_if.source rsp_if
);
   localparam int SW = $clog2(SLOTS);
   localparam int KW = $clog2(MAX_KEY + 1);
   localparam int BW = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
   localparam int OW = $clog2(STORE_BYTES);
   localparam int FW = $clog2(STORE_BYTES + 1);
   localparam int CW = $clog2(SLOTS + 1);
   localparam int NW = KW + 4;

   req_type in_q;

   state_type state_ff, state_in;

   // memories
   logic [7:0]  key_mem [MAX_KEY];
   logic [7:0]  str_mem [STORE_BYTES];
   logic [31:0] shash_mem [SLOTS];
   logic [KW-1:0] slen_mem [SLOTS];
   logic [OW-1:0] soff_mem [SLOTS];
   logic [SLOTS-1:0] used_ff;

   logic [KW-1:0] klen_ff, klen_in;
   logic          ovf_ff, ovf_in;
   logic          last_ff, last_in;
   logic [SW-1:0] idx_ff, idx_in;
   logic [CW-1:0] probes_ff, probes_in;
   logic [KW-1:0] pos_ff, pos_in;
   logic [NW-1:0] need_ff, need_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [CW-1:0] count_ff, count_in;
   rsp_type       res_ff, res_in;
   rsp_type       out_ff, out_in;
   logic          ovalid_ff, ovalid_in;

   logic [31:0]   hash;
   logic          hclear, hfold;

   logic [31:0]   rd_hash_ff;
   logic [KW-1:0] rd_len_ff;
   logic [OW-1:0] rd_off_ff;
   logic [7:0]    rd_key_ff, rd_str_ff;

   logic          key_we, str_we, slot_we;
   logic [BW-1:0] key_waddr, key_raddr;
   logic [OW-1:0] str_addr;
   logic [7:0]    str_wdata;

   logic [NW-1:0]    need_calc;
   logic [FW+NW-1:0] fill_sum;

   assign in_q = req_if.data;

   sit_hash u_hash (
      .clock (clock),
      .reset (reset),
      .clear (hclear),
      .fold  (hfold),
      .data  (in_q.key_byte),
      .hash  (hash)
   );

   assign req_if.ready = (state_ff == S_COLLECT);
   assign rsp_if.valid = ovalid_ff;
   assign rsp_if.data  = out_ff;

   assign need_calc = ({{(NW-KW){1'b0}}, klen_ff} + NW'(8)) & ~NW'(7);
   assign fill_sum  = {{NW{1'b0}}, fill_ff} + {{FW{1'b0}}, need_ff};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_COLLECT:   if (req_if.valid) state_in = S_HASH;
         S_HASH:      state_in = !last_ff ? S_COLLECT :
                                 (ovf_ff ? S_RESP : S_PROBE_RD);
         S_PROBE_RD:  state_in = S_PROBE_CHK;
         S_PROBE_CHK: begin
            if (!used_ff[idx_ff] || probes_ff == CW'(SLOTS)) state_in = S_INS_CHK;
            else if (rd_hash_ff == hash && rd_len_ff == klen_ff)
               state_in = (klen_ff == '0) ? S_RESP : S_CMP_RD;
            else state_in = S_PROBE_RD;
         end
         S_CMP_RD:    state_in = S_CMP_CHK;
         S_CMP_CHK: begin
            if (rd_key_ff != rd_str_ff) state_in = S_PROBE_RD;
            else if (pos_ff + KW'(1) == klen_ff) state_in = S_RESP;
            else state_in = S_CMP_RD;
         end
         S_INS_CHK: begin
            if ({count_ff, 1'b0} >= (CW+1)'(SLOTS) || probes_ff == CW'(SLOTS))
               state_in = S_RESP;
            else if (fill_sum > (FW+NW)'(STORE_BYTES)) state_in = S_RESP;
            else state_in = S_INS_WR;
         end
         S_INS_WR:  if (NW'(pos_ff) + NW'(1) >= need_ff) state_in = S_SLOT_WR;
         S_SLOT_WR: state_in = S_RESP;
         S_RESP:    if (!ovalid_ff || rsp_if.ready) state_in = S_COLLECT;
         default:   state_in = S_COLLECT;
      endcase
   end

   always_comb begin
      klen_in = klen_ff; ovf_in = ovf_ff; last_in = last_ff;
      idx_in = idx_ff; probes_in = probes_ff; pos_in = pos_ff; need_in = need_ff;
      fill_in = fill_ff; count_in = count_ff; res_in = res_ff; out_in = out_ff;
      ovalid_in = ovalid_ff && !rsp_if.ready;
      hclear = 1'b0; hfold = 1'b0;
      key_we = 1'b0; str_we = 1'b0; slot_we = 1'b0;
      key_waddr = klen_ff[BW-1:0];
      key_raddr = pos_ff[BW-1:0];
      str_addr = rd_off_ff + OW'(pos_ff);
      str_wdata = 8'd0;
      unique case (state_ff)
         S_COLLECT: if (req_if.valid) begin
            last_in = in_q.end_of_key;
            if (in_q.byte_present) begin
               hfold = 1'b1;
               if (klen_ff < KW'(MAX_KEY)) begin
                  key_we = 1'b1;
                  klen_in = klen_ff + KW'(1);
               end else ovf_in = 1'b1;
            end
         end
         S_HASH: begin
            idx_in = hash[SW-1:0];
            probes_in = '0;
            pos_in = '0;
            res_in = '0;
            if (ovf_ff) res_in.status = ST_KEY_LONG;
         end
         S_PROBE_CHK: begin
            pos_in = '0;
            if (used_ff[idx_ff] && probes_ff != CW'(SLOTS) &&
                rd_hash_ff == hash && rd_len_ff == klen_ff && klen_ff == '0) begin
               res_in.slot_index = 8'(idx_ff);
               res_in.string_offset = 14'(rd_off_ff);
            end
            if (used_ff[idx_ff] && probes_ff != CW'(SLOTS) &&
                !(rd_hash_ff == hash && rd_len_ff == klen_ff)) begin
               idx_in = idx_ff + SW'(1);
               probes_in = probes_ff + CW'(1);
            end
            need_in = need_calc;
         end
         S_CMP_CHK: begin
            if (rd_key_ff != rd_str_ff) begin
               idx_in = idx_ff + SW'(1);
               probes_in = probes_ff + CW'(1);
            end else if (pos_ff + KW'(1) == klen_ff) begin
               res_in.slot_index = 8'(idx_ff);
               res_in.string_offset = 14'(rd_off_ff);
            end else pos_in = pos_ff + KW'(1);
         end
         S_INS_CHK: begin
            pos_in = '0;
            key_raddr = '0;
            if ({count_ff, 1'b0} >= (CW+1)'(SLOTS) || probes_ff == CW'(SLOTS))
               res_in.status = ST_HALF_LOAD;
            else if (fill_sum > (FW+NW)'(STORE_BYTES))
               res_in.status = ST_STORE_FULL;
         end
         S_INS_WR: begin
            key_raddr = pos_ff[BW-1:0] + BW'(1);
            str_we = 1'b1;
            str_addr = fill_ff[OW-1:0] + OW'(pos_ff);
            str_wdata = (pos_ff < klen_ff) ? rd_key_ff : 8'd0;
            pos_in = pos_ff + KW'(1);
         end
         S_SLOT_WR: begin
            slot_we = 1'b1;
            res_in.slot_index = 8'(idx_ff);
            res_in.string_offset = 14'(fill_ff);
            res_in.newly_added = 1'b1;
            fill_in = FW'(fill_sum);
            count_in = count_ff + CW'(1);
         end
         S_RESP: if (!ovalid_ff || rsp_if.ready) begin
            ovalid_in = 1'b1;
            out_in = res_ff;
            hclear = 1'b1;
            klen_in = '0;
            ovf_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (key_we) key_mem[key_waddr] <= in_q.key_byte;
      rd_key_ff <= key_mem[key_raddr];
      if (str_we) str_mem[str_addr] <= str_wdata;
      rd_str_ff <= str_mem[str_addr];
      if (slot_we) begin
         shash_mem[idx_ff] <= hash;
         slen_mem[idx_ff]  <= klen_ff;
         soff_mem[idx_ff]  <= fill_ff[OW-1:0];
      end
      rd_hash_ff <= shash_mem[idx_ff];
      rd_len_ff  <= slen_mem[idx_ff];
      rd_off_ff  <= soff_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_COLLECT;
         klen_ff <= '0; ovf_ff <= 1'b0; fill_ff <= '0; count_ff <= '0;
         used_ff <= '0; ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         klen_ff <= klen_in; ovf_ff <= ovf_in; fill_ff <= fill_in;
         count_ff <= count_in; ovalid_ff <= ovalid_in;
         if (slot_we) used_ff[idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in; idx_ff <= idx_in;
      probes_ff <= probes_in; pos_ff <= pos_in; need_ff <= need_in;
      res_ff <= res_in; out_ff <= out_in;
   end

   a_one_hot_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.data.status != ST_OK |-> rsp_if.data.newly_added == 1'b0)
      else $error("error response flagged as insert");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(STORE_BYTES))
      else $error("store fill beyond capacity");
   a_count_grow: assert property (@(posedge clock) disable iff (reset)
      count_ff != $past(count_ff) |-> $past(state_ff) == S_SLOT_WR)
      else $error("entry count moved outside insert");
endmodule

// File: rtl/sit_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FNV-1a hash step
// Folds one byte into the running hash per cycle while fold is asserted.
// ----------------------------------------------------------------------------
module sit_hash
   import sit_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        clear,
   input  logic        fold,
   input  logic [7:0]  data,
   output logic [31:0] hash
);
   logic [31:0] hash_ff, hash_in;

   always_comb begin
      hash_in = hash_ff;
      if (clear) hash_in = FNV_BASIS;
      else if (fold) hash_in = (hash_ff ^ {24'd0, data}) * FNV_PRIME;
   end

   always_ff @(posedge clock) begin
      if (reset) hash_ff <= FNV_BASIS;
      else hash_ff <= hash_in;
   end

   assign hash = hash_ff;
endmodule
